>>> rtl/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared constants, register map and character tables for the modem
// response matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mrm_pkg;

  // largest response pattern the matcher compares
  localparam int unsigned MAX_PATTERN_CHARS = 16;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned NOTIFY_LEN = 7;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

  typedef enum logic [1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_MSG_WAIT_MODE  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_ARM  = 1'b1
  } op_t;

  // "+CMTI: " notification header, positions past the end map to the first char
  function automatic logic [CHAR_W-1:0] notify_char(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    c = 8'h2B;
    case (pos)
      5'd0:    c = 8'h2B;
      5'd1:    c = 8'h43;
      5'd2:    c = 8'h4D;
      5'd3:    c = 8'h54;
      5'd4:    c = 8'h49;
      5'd5:    c = 8'h3A;
      5'd6:    c = 8'h20;
      default: c = 8'h2B;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/modem_response_matcher.sv
// ----------------------------------------------------------------------------
// modem_response_matcher
// Streams received modem bytes against a configured response pattern or,
// in message-wait mode, against a new-message notification with index parse.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  input    | in_valid, in_stall, in_op, in_rx_byte  | in
//  result   | out_valid, out_stall, out_done_res,    | out
//           | out_listening, out_index_valid,        |
//           | out_message_index                      |
//  config   | psel, penable, pwrite, paddr, pwdata,  | apb
//           | prdata, pready                         |
//
// The match state updates at acceptance and the result lands in the output
// register on the same edge, so one word per cycle is sustained while no
// result is held; out_valid rises in the cycle after acceptance.
// A stalled result holds the output register; in_stall is raised only while
// a held result is not being taken. Reset (rst_n, synchronous) disarms the
// matcher and clears all matching state and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module modem_response_matcher (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_op,
  input  wire logic [7:0]                    in_rx_byte,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_done_res,
  output logic                               out_listening,
  output logic                               out_index_valid,
  output logic [7:0]                         out_message_index,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mrm_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [mrm_pkg::DATA_W-1:0]    pwdata,
  output logic      [mrm_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  import mrm_pkg::*;

  // configuration registers
  logic [DATA_W-1:0] pattern_low_r;
  logic [DATA_W-1:0] pattern_high_r;
  logic [LEN_W-1:0]  pattern_length_r;
  logic              msg_wait_mode_r;

  // matching state
  logic [POS_W-1:0]  match_pos_r,  match_pos_nxt;
  logic              armed_r,      armed_nxt;
  logic              await_eol_r,  await_eol_nxt;
  logic              comma_seen_r, comma_seen_nxt;
  logic [7:0]        index_acc_r,  index_acc_nxt;
  logic [7:0]        last_index_r, last_index_nxt;

  // output register
  logic              out_valid_r;
  logic              out_done_r,   out_done_nxt;
  logic              out_idx_vld_r, out_idx_vld_nxt;

  logic              in_accept;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  logic [LEN_W-1:0]  user_len;
  logic [LEN_W-1:0]  active_len;
  logic [POS_W-1:0]  pos_eff;
  logic [POS_W-1:0]  pos_inc;
  logic [CHAR_W-1:0] char_at_pos;
  logic [CHAR_W-1:0] char_first;
  logic [2*DATA_W-1:0] pattern_all;
  logic [CHAR_W-1:0] user_char;
  logic              hit;
  logic [POS_W-1:0]  pos_new;
  logic [7:0]        digit_acc;
  logic              is_digit;

  assign pready = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_comb begin
    case (cfg_idx)
      REG_PATTERN_LOW:    prdata = pattern_low_r;
      REG_PATTERN_HIGH:   prdata = pattern_high_r;
      REG_PATTERN_LENGTH: prdata = {{(DATA_W-LEN_W){1'b0}}, pattern_length_r};
      REG_MSG_WAIT_MODE:  prdata = {{(DATA_W-1){1'b0}}, msg_wait_mode_r};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_low_r    <= '0;
      pattern_high_r   <= '0;
      pattern_length_r <= LEN_W'(2);
      msg_wait_mode_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PATTERN_LOW:    pattern_low_r    <= pwdata;
        REG_PATTERN_HIGH:   pattern_high_r   <= pwdata;
        REG_PATTERN_LENGTH: pattern_length_r <= pwdata[LEN_W-1:0];
        REG_MSG_WAIT_MODE:  msg_wait_mode_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // effective length: user length clamped to 1..MAX_PATTERN_CHARS, or the line-end or notify length
  always_comb begin
    if (pattern_length_r == '0) begin
      user_len = LEN_W'(1);
    end else if (pattern_length_r > LEN_W'(MAX_PATTERN_CHARS)) begin
      user_len = LEN_W'(MAX_PATTERN_CHARS);
    end else begin
      user_len = pattern_length_r;
    end
    if (await_eol_r) begin
      active_len = LEN_W'(2);
    end else if (msg_wait_mode_r) begin
      active_len = LEN_W'(NOTIFY_LEN);
    end else begin
      active_len = user_len;
    end
  end

  assign pattern_all = {pattern_high_r, pattern_low_r};
  // stale position after a length change restarts at the first char
  assign pos_eff   = (match_pos_r >= active_len) ? '0 : match_pos_r;
  assign user_char = pattern_all[{pos_eff[3:0], 3'b000} +: CHAR_W];
  assign pos_inc   = pos_eff + POS_W'(1);

  always_comb begin
    if (await_eol_r) begin
      char_at_pos = pos_eff[0] ? CHAR_LF : CHAR_CR;
      char_first  = CHAR_CR;
    end else if (msg_wait_mode_r) begin
      char_at_pos = notify_char(pos_eff);
      char_first  = notify_char('0);
    end else begin
      char_at_pos = user_char;
      char_first  = pattern_low_r[CHAR_W-1:0];
    end
  end

  assign is_digit  = (in_rx_byte >= CHAR_ZERO) && (in_rx_byte <= CHAR_NINE);
  // acc * 10 + digit, modulo 256
  assign digit_acc = {index_acc_r[4:0], 3'b000} + {index_acc_r[6:0], 1'b0}
                   + (in_rx_byte - CHAR_ZERO);

  always_comb begin
    match_pos_nxt   = match_pos_r;
    armed_nxt       = armed_r;
    await_eol_nxt   = await_eol_r;
    comma_seen_nxt  = comma_seen_r;
    index_acc_nxt   = index_acc_r;
    last_index_nxt  = last_index_r;
    out_done_nxt    = 1'b0;
    out_idx_vld_nxt = 1'b0;
    hit             = 1'b0;
    pos_new         = '0;

    if (op_t'(in_op) == OP_ARM) begin
      armed_nxt      = 1'b1;
      match_pos_nxt  = '0;
      await_eol_nxt  = 1'b0;
      comma_seen_nxt = 1'b0;
      index_acc_nxt  = '0;
    end else if (armed_r && (in_rx_byte != CHAR_NUL)) begin
      if (await_eol_r) begin
        if (comma_seen_r) begin
          if (is_digit) begin
            index_acc_nxt = digit_acc;
          end
        end else if (in_rx_byte == CHAR_COMMA) begin
          comma_seen_nxt = 1'b1;
        end
      end

      // simple fallback: on mismatch retry against the first char
      if (in_rx_byte == char_at_pos) begin
        pos_new = pos_inc;
        hit     = 1'b1;
      end else if (in_rx_byte == char_first) begin
        pos_new = POS_W'(1);
        hit     = 1'b1;
      end

      match_pos_nxt = pos_new;
      if (hit && (pos_new >= active_len)) begin
        match_pos_nxt = '0;
        if (await_eol_r) begin
          last_index_nxt  = index_acc_nxt;
          out_idx_vld_nxt = 1'b1;
          await_eol_nxt   = 1'b0;
          out_done_nxt    = 1'b1;
          armed_nxt       = 1'b0;
        end else if (msg_wait_mode_r) begin
          await_eol_nxt  = 1'b1;
          comma_seen_nxt = 1'b0;
          index_acc_nxt  = '0;
        end else begin
          out_done_nxt = 1'b1;
          armed_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_pos_r   <= '0;
      armed_r       <= 1'b0;
      await_eol_r   <= 1'b0;
      comma_seen_r  <= 1'b0;
      index_acc_r   <= '0;
      last_index_r  <= '0;
      out_valid_r   <= 1'b0;
      out_done_r    <= 1'b0;
      out_idx_vld_r <= 1'b0;
    end else begin
      if (in_accept) begin
        match_pos_r   <= match_pos_nxt;
        armed_r       <= armed_nxt;
        await_eol_r   <= await_eol_nxt;
        comma_seen_r  <= comma_seen_nxt;
        index_acc_r   <= index_acc_nxt;
        last_index_r  <= last_index_nxt;
        out_valid_r   <= 1'b1;
        out_done_r    <= out_done_nxt;
        out_idx_vld_r <= out_idx_vld_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // listening and index follow the state that the last accepted word left
  assign out_valid         = out_valid_r;
  assign out_done_res      = out_done_r;
  assign out_listening     = armed_r;
  assign out_index_valid   = out_idx_vld_r;
  assign out_message_index = last_index_r;

endmodule

`default_nettype wire

>>> bench/modem_response_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modem_response_matcher_tb
// Drives received bytes and arm words into the matcher and checks every
// result word against a cycle-free predictor kept in the bench. Covers
// pattern matching with restart on mismatch, stale match positions after
// length changes, and "+CMTI: " notification parsing with index wrap,
// under three sender/receiver stall mixes and many register settings.
// ----------------------------------------------------------------------------
module modem_response_matcher_tb;
  import mrm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned WORDS_PER_MIX  = 550;
  localparam logic [55:0] CMTI_TEXT      = "+CMTI: ";
  localparam logic [7:0]  CHAR_QUOTE     = 8'h22;

  typedef struct packed {
    logic       done;
    logic       listening;
    logic       idx_valid;
    logic [7:0] msg_idx;
  } match_resp_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  op_t                 in_op      = OP_BYTE;
  logic [7:0]          in_rx_byte = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic                out_done_res;
  logic                out_listening;
  logic                out_index_valid;
  logic [7:0]          out_message_index;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [ADDR_W-1:0]   paddr      = '0;
  logic [DATA_W-1:0]   pwdata     = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // bench copy of the registers and matching state
  logic [63:0] pat_lo         = '0;
  logic [63:0] pat_hi         = '0;
  logic [4:0]  pat_len        = 5'd2;
  logic        wait_mode      = 1'b0;
  logic [4:0]  match_pos      = '0;
  logic        armed          = 1'b0;
  logic        line_end_phase = 1'b0;
  logic        comma_seen     = 1'b0;
  logic [7:0]  index_acc      = '0;
  logic [7:0]  last_index     = '0;

  match_resp_t pending_responses[$];
  int          send_idle_pct = 35;
  int          recv_idle_pct = 73;
  int          n_words       = 0;
  int          n_done        = 0;
  int          n_index       = 0;
  int          n_cfg_writes  = 0;
  int          n_errors      = 0;
  int unsigned idle_cycles   = 0;

  always #6 clk = ~clk;

  modem_response_matcher DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_done_res      (out_done_res),
    .out_listening     (out_listening),
    .out_index_valid   (out_index_valid),
    .out_message_index (out_message_index),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  function automatic logic [7:0] cmti_chr(int unsigned i);
    return CMTI_TEXT[8*(6-i) +: 8];
  endfunction

  function automatic logic [7:0] pattern_chr(int unsigned i);
    if (i < 8) return pat_lo[8*i +: 8];
    return pat_hi[8*(i-8) +: 8];
  endfunction

  // length register clamps to 1..MAX_PATTERN_CHARS
  function automatic int unsigned pattern_chars();
    int unsigned n;
    n = pat_len;
    if (n == 0) n = 1;
    if (n > MAX_PATTERN_CHARS) n = MAX_PATTERN_CHARS;
    return n;
  endfunction

  function automatic logic [7:0] awaited_chr(int unsigned p);
    if (line_end_phase) return (p % 2) ? CHAR_LF : CHAR_CR;
    if (wait_mode) return (p < NOTIFY_LEN) ? cmti_chr(p) : cmti_chr(0);
    return pattern_chr(p % 16);
  endfunction

  function automatic int unsigned awaited_len();
    if (line_end_phase) return 2;
    if (wait_mode) return NOTIFY_LEN;
    return pattern_chars();
  endfunction

  function automatic match_resp_t advance_matcher(op_t op, logic [7:0] b);
    match_resp_t r;
    int unsigned len;
    int unsigned p;
    logic        hit;
    r = '0;
    if (op == OP_ARM) begin
      armed          = 1'b1;
      match_pos      = '0;
      line_end_phase = 1'b0;
      comma_seen     = 1'b0;
      index_acc      = '0;
    end else if (armed && b != CHAR_NUL) begin
      len = awaited_len();
      p   = match_pos;
      if (line_end_phase) begin
        if (comma_seen) begin
          if (b >= CHAR_ZERO && b <= CHAR_NINE) index_acc = index_acc * 8'd10 + (b - CHAR_ZERO);
        end else if (b == CHAR_COMMA) begin
          comma_seen = 1'b1;
        end
      end
      if (p >= len) p = 0;
      // restart falls back to the first character only
      if (b == awaited_chr(p)) begin
        p++;
        hit = 1'b1;
      end else if (b == awaited_chr(0)) begin
        p   = 1;
        hit = 1'b1;
      end else begin
        p   = 0;
        hit = 1'b0;
      end
      if (hit && p >= len) begin
        p = 0;
        if (line_end_phase) begin
          last_index     = index_acc;
          r.idx_valid    = 1'b1;
          line_end_phase = 1'b0;
          r.done         = 1'b1;
          armed          = 1'b0;
        end else if (wait_mode) begin
          line_end_phase = 1'b1;
          comma_seen     = 1'b0;
          index_acc      = '0;
        end else begin
          r.done = 1'b1;
          armed  = 1'b0;
        end
      end
      match_pos = p[4:0];
    end
    r.listening = armed;
    r.msg_idx   = last_index;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  task automatic send_word(op_t op, logic [7:0] b);
    match_resp_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_words++;
    r = advance_matcher(op, b);
    pending_responses.push_back(r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t r, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (r)
      REG_PATTERN_LOW:    pat_lo    = v;
      REG_PATTERN_HIGH:   pat_hi    = v;
      REG_PATTERN_LENGTH: pat_len   = v[4:0];
      REG_MSG_WAIT_MODE:  wait_mode = v[0];
      default: ;
    endcase
    n_cfg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(6))
      0:       return CHAR_NUL;
      1:       return pattern_chr(0);
      2:       return pattern_chr($urandom_range(15));
      3:       return cmti_chr(0);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] body_char();
    case ($urandom_range(7))
      0:       return CHAR_QUOTE;
      1:       return "S";
      2:       return CHAR_COMMA;
      3, 4:    return CHAR_ZERO + 8'($urandom_range(9));
      5:       return CHAR_CR;
      6:       return CHAR_NUL;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_noise();
    if ($urandom_range(99) < 4) send_word(OP_ARM, 8'($urandom_range(255)));
    else send_word(OP_BYTE, noise_byte());
  endtask

  task automatic random_config();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  n;
    settle();
    case ($urandom_range(7))
      0:       begin lo = '1; hi = '1; end
      1:       begin lo = '0; hi = '0; end
      2:       begin lo = {$urandom, $urandom}; hi = {$urandom, $urandom}; end
      default: begin
        // small alphabet so partial matches and restarts are common
        for (int i = 0; i < 8; i++) begin
          lo[8*i +: 8] = 8'h41 + 8'($urandom_range(3));
          hi[8*i +: 8] = 8'h41 + 8'($urandom_range(3));
        end
      end
    endcase
    case ($urandom_range(9))
      0:       n = 5'd0;
      1:       n = 5'd31;
      2:       n = 5'd16;
      3:       n = 5'd1;
      4:       n = 5'($urandom_range(17, 30));
      default: n = 5'($urandom_range(2, 8));
    endcase
    cfg_write(REG_PATTERN_LOW, lo);
    cfg_write(REG_PATTERN_HIGH, hi);
    cfg_write(REG_PATTERN_LENGTH, 64'(n));
    cfg_write(REG_MSG_WAIT_MODE, 64'($urandom_range(1)));
  endtask

  task automatic pattern_sequence();
    int unsigned len;
    int unsigned bad;
    int unsigned stop_at;
    logic [7:0]  b;
    if ($urandom_range(99) < 85) send_word(OP_ARM, 8'($urandom_range(255)));
    repeat ($urandom_range(3)) send_noise();
    len     = pattern_chars();
    bad     = ($urandom_range(99) < 20) ? $urandom_range(len - 1) : len;
    stop_at = ($urandom_range(99) < 10) ? $urandom_range(len - 1) : len;
    for (int unsigned i = 0; i < stop_at; i++) begin
      b = (i == bad) ? 8'($urandom_range(255)) : pattern_chr(i);
      if ($urandom_range(99) < 5) send_word(OP_BYTE, CHAR_NUL);
      send_word(OP_BYTE, b);
    end
    repeat ($urandom_range(2)) send_noise();
  endtask

  task automatic notify_sequence();
    int unsigned bad;
    if ($urandom_range(99) < 85) send_word(OP_ARM, 8'($urandom_range(255)));
    repeat ($urandom_range(2)) send_noise();
    bad = ($urandom_range(99) < 15) ? $urandom_range(6) : 7;
    for (int unsigned i = 0; i < 7; i++)
      send_word(OP_BYTE, (i == bad) ? 8'($urandom_range(255)) : cmti_chr(i));
    repeat ($urandom_range(3)) send_word(OP_BYTE, body_char());
    if ($urandom_range(99) < 80) send_word(OP_BYTE, CHAR_COMMA);
    repeat ($urandom_range(4)) send_word(OP_BYTE, CHAR_ZERO + 8'($urandom_range(9)));
    repeat ($urandom_range(2)) send_word(OP_BYTE, body_char());
    case ($urandom_range(9))
      0:       send_word(OP_BYTE, CHAR_CR);
      1:       ;
      default: begin
        send_word(OP_BYTE, CHAR_CR);
        send_word(OP_BYTE, CHAR_LF);
      end
    endcase
    repeat ($urandom_range(1)) send_noise();
  endtask

  // bytes before arming, zero bytes, arm with a dirty byte field
  task automatic test_unarmed_and_zero();
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_ARM, 8'hFF);
    send_word(OP_BYTE, CHAR_NUL);
    send_word(OP_BYTE, 8'h80);
  endtask

  // "OK\r\n" with a doubled first char to force the restart path
  task automatic test_pattern_fallback();
    settle();
    cfg_write(REG_PATTERN_LOW, {32'h0, CHAR_LF, CHAR_CR, 8'("K"), 8'("O")});
    cfg_write(REG_PATTERN_HIGH, '1);
    cfg_write(REG_PATTERN_LENGTH, 64'd4);
    send_word(OP_ARM, 8'h00);
    send_word(OP_BYTE, "O");
    send_word(OP_BYTE, "O");
    send_word(OP_BYTE, "K");
    send_word(OP_BYTE, CHAR_CR);
    send_word(OP_BYTE, CHAR_LF);
  endtask

  // shrink the length under a partial match; zero length acts as one
  task automatic test_stale_position();
    send_word(OP_ARM, 8'h00);
    send_word(OP_BYTE, "O");
    send_word(OP_BYTE, "K");
    settle();
    cfg_write(REG_PATTERN_LENGTH, 64'd0);
    send_word(OP_BYTE, "O");
  endtask

  // header in notify mode, then line end after a mode switch; 259 wraps to 3
  task automatic test_notification_index();
    settle();
    cfg_write(REG_MSG_WAIT_MODE, 64'd1);
    send_word(OP_ARM, 8'h00);
    for (int unsigned i = 0; i < 7; i++) send_word(OP_BYTE, cmti_chr(i));
    settle();
    cfg_write(REG_MSG_WAIT_MODE, 64'd0);
    send_word(OP_BYTE, CHAR_COMMA);
    send_word(OP_BYTE, "2");
    send_word(OP_BYTE, "5");
    send_word(OP_BYTE, "9");
    send_word(OP_BYTE, CHAR_CR);
    send_word(OP_BYTE, CHAR_LF);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int words);
    int stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at       = n_words + words;
    while (n_words < stop_at) begin
      random_config();
      repeat ($urandom_range(2, 6)) begin
        if (wait_mode) notify_sequence();
        else pattern_sequence();
      end
    end
  endtask

  always @(posedge clk) begin
    match_resp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_responses.pop_front();
        if (out_done_res !== want.done)
          report_mismatch("done_res", out_done_res, want.done);
        if (out_listening !== want.listening)
          report_mismatch("listening", out_listening, want.listening);
        if (out_index_valid !== want.idx_valid)
          report_mismatch("index_valid", out_index_valid, want.idx_valid);
        if (out_message_index !== want.msg_idx)
          report_mismatch("message_index", out_message_index, want.msg_idx);
        n_done  += int'(want.done);
        n_index += int'(want.idx_valid);
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unarmed_and_zero();
    test_pattern_fallback();
    test_stale_position();
    test_notification_index();
    test_random_traffic(35, 73, WORDS_PER_MIX);
    test_random_traffic(73, 35, WORDS_PER_MIX);
    test_random_traffic(0, 0, WORDS_PER_MIX);
    settle();
    repeat (4) @(posedge clk);
    $display("%0d words sent, %0d completed responses, %0d parsed indices",
             n_words, n_done, n_index);
    $display("%0d register writes over pattern and notify modes, three stall mixes",
             n_cfg_writes);
    if (n_errors == 0 && pending_responses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mrm_pkg.sv
rtl/modem_response_matcher.sv
bench/modem_response_matcher_tb.sv
